// File: sv/dpf_pkg.sv
// Package for the detection proposal filter: value types, field widths,
// register indexes and reset values. Used by the channel interfaces and the top level.
// No dependencies.
package dpf_pkg;

    // Fixed-point value format (Q16.16, two's complement).
    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;

    // Record layout: five box fields, then the class scores.
    localparam int BOX_FIELDS  = 5;
    localparam int MAX_CLASSES = 128;

    // Field and register widths.
    localparam int POS_W       = 8;
    localparam int LABEL_W     = 7;
    localparam int ANCHOR_W    = 16;
    localparam int CLASS_CNT_W = 8;
    localparam int THRESH_W    = 17;
    localparam int CFG_DATA_W  = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int PROD_W      = 2 * VALUE_WIDTH;

    // Element positions of the box fields within a record.
    localparam logic [POS_W-1:0] POS_CENTRE_X   = POS_W'(0);
    localparam logic [POS_W-1:0] POS_CENTRE_Y   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_WIDTH      = POS_W'(2);
    localparam logic [POS_W-1:0] POS_HEIGHT     = POS_W'(3);
    localparam logic [POS_W-1:0] POS_OBJECTNESS = POS_W'(4);
    localparam logic [POS_W-1:0] POS_FIRST_CLS  = POS_W'(BOX_FIELDS);
    localparam logic [POS_W-1:0] POS_LAST_BASE  = POS_W'(BOX_FIELDS - 1);
    localparam logic [POS_W-1:0] POS_MAX        = POS_W'(BOX_FIELDS - 1 + MAX_CLASSES);

    // Configuration register defaults.
    localparam logic [CLASS_CNT_W-1:0] CLASS_COUNT_RESET    = CLASS_CNT_W'(80);
    localparam logic [ANCHOR_W-1:0]    ANCHOR_COUNT_RESET   = ANCHOR_W'(8400);
    localparam logic [THRESH_W-1:0]    CONF_THRESHOLD_RESET = THRESH_W'(16384);

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic [VALUE_WIDTH-1:0]        t_mag;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLASS_COUNT    = 2'd0,
        CFG_ANCHOR_COUNT   = 2'd1,
        CFG_CONF_THRESHOLD = 2'd2
    } t_cfg_reg;

endpackage

// File: sv/dpf_in_if.sv
// Input channel of the detection proposal filter: one network output element per item.
// Depends on dpf_pkg.
interface dpf_in_if;
    import dpf_pkg::*;

    logic   valid;
    logic   ready;
    t_value value;

    modport source(output valid, output value, input ready);
    modport sink(input valid, input value, output ready);
endinterface

// File: sv/dpf_out_if.sv
// Result channel of the detection proposal filter: one box (top-left corner and size) per item.
// Depends on dpf_pkg.
interface dpf_out_if;
    import dpf_pkg::*;

    logic                valid;
    logic                ready;
    t_value              box_left;
    t_value              box_top;
    t_value              box_width;
    t_value              box_height;
    logic [LABEL_W-1:0]  class_label;
    t_value              score;
    logic [ANCHOR_W-1:0] anchor_index;

    modport source(
        output valid, output box_left, output box_top, output box_width,
        output box_height, output class_label, output score, output anchor_index,
        input ready
    );
    modport sink(
        input valid, input box_left, input box_top, input box_width,
        input box_height, input class_label, input score, input anchor_index,
        output ready
    );
endinterface

// File: sv/dpf_cfg_if.sv
// Configuration write channel of the detection proposal filter.
// Depends on dpf_pkg.
interface dpf_cfg_if;
    import dpf_pkg::*;

    logic                  valid;
    logic                  ready;
    t_cfg_reg              index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// File: sv/detection_proposal_filter_top.sv
// Channel      | Dir | Payload
// -------------+-----+------------------------------------------------------------
// i_cfg        | in  | index (register), data (write value)
// i_det        | in  | value: one Q16.16 network output element
// o_box        | out | box_left, box_top, box_width, box_height, class_label,
//              |     | score, anchor_index
//
// One item is accepted every cycle; a stall on o_box only backs up once the
// four pipeline registers (input, record, product, result) hold items.
// After the last element of a record is accepted, its box passes through the
// record, product and result registers; the 32x32 magnitude multiply lies
// between the record and product registers. Reset (i_rst_n low, synchronous)
// empties the pipeline, restarts the record and anchor counters and restores
// the register defaults. Configuration writes are taken every cycle.
//
// Top level of the detection proposal filter. Depends on dpf_pkg and the
// interfaces dpf_in_if, dpf_out_if and dpf_cfg_if.
module detection_proposal_filter_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dpf_cfg_if.sink    i_cfg,
    dpf_in_if.sink     i_det,
    dpf_out_if.source  o_box
);
    import dpf_pkg::*;

    // Configuration registers.
    logic [CLASS_CNT_W-1:0] r_class_count;
    logic [ANCHOR_W-1:0]    r_anchor_count;
    logic [THRESH_W-1:0]    r_conf_threshold;

    // Stage 0: input register.
    logic   r_v0;
    t_value r_val0;

    // Record state.
    logic [POS_W-1:0]    r_pos;
    logic [ANCHOR_W-1:0] r_anchor;
    t_value              r_cx, r_cy, r_w, r_h, r_obj, r_best;
    logic [LABEL_W-1:0]  r_best_cls;

    // Stage 1: finished record.
    logic                r_v1;
    t_value              r_cx1, r_cy1, r_w1, r_h1, r_obj1, r_best1;
    logic [LABEL_W-1:0]  r_cls1;
    logic [ANCHOR_W-1:0] r_idx1;

    // Stage 2: product and box corners.
    logic                r_v2;
    logic [PROD_W-1:0]   r_prod2;
    logic                r_neg2;
    logic                r_obj_ok2;
    t_value              r_left2, r_top2, r_w2, r_h2;
    logic [LABEL_W-1:0]  r_cls2;
    logic [ANCHOR_W-1:0] r_idx2;

    // Stage 3: result register.
    logic                r_v3;
    t_value              r_left3, r_top3, r_w3, r_h3, r_score3;
    logic [LABEL_W-1:0]  r_cls3;
    logic [ANCHOR_W-1:0] r_idx3;

    // Pipeline flow control.
    logic en0, en1, en2, en3;
    logic move0, move1, move2;
    logic last0, pass2;

    // Record decode signals.
    logic [POS_W-1:0]    classes;
    logic [POS_W-1:0]    last_pos;
    t_value              n_cx, n_cy, n_w, n_h, n_obj, n_best;
    logic [LABEL_W-1:0]  n_best_cls;
    logic [POS_W-1:0]    n_pos;
    logic [ANCHOR_W-1:0] n_anchor;
    logic [ANCHOR_W:0]   anchor_inc;

    // Stage 1 to 2 signals.
    t_mag                   mag_best, mag_obj;
    logic                   neg1;
    logic signed [VALUE_WIDTH:0] thr_ext;
    t_value                 left1, top1;

    // Stage 2 to 3 signals.
    logic [PROD_W-1:0]           rounded;
    logic [PROD_W-FRAC_BITS-1:0] mag_q, limit_q, sat_q;
    t_value                      prod2;

    // Saturating a - floor(b / 2).
    function automatic t_value sub_half(input t_value a, input t_value b);
        logic signed [VALUE_WIDTH:0] diff;
        diff = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b[VALUE_WIDTH-1], b[VALUE_WIDTH-1:1]};
        if (diff[VALUE_WIDTH] != diff[VALUE_WIDTH-1]) begin
            return diff[VALUE_WIDTH] ? {1'b1, {(VALUE_WIDTH-1){1'b0}}}
                                     : {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end
        return diff[VALUE_WIDTH-1:0];
    endfunction

    // Magnitude of a two's complement value, exact for the most negative one.
    function automatic t_mag abs_val(input t_value v);
        return v[VALUE_WIDTH-1] ? t_mag'(~v + 1'b1) : t_mag'(v);
    endfunction

    // Configuration port is always ready.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_count    <= CLASS_COUNT_RESET;
            r_anchor_count   <= ANCHOR_COUNT_RESET;
            r_conf_threshold <= CONF_THRESHOLD_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_CLASS_COUNT:    r_class_count    <= i_cfg.data[CLASS_CNT_W-1:0];
                CFG_ANCHOR_COUNT:   r_anchor_count   <= i_cfg.data[ANCHOR_W-1:0];
                CFG_CONF_THRESHOLD: r_conf_threshold <= i_cfg.data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // Flow control: each stage moves when the next one is empty or moving.
    // Records that fail the threshold drop out without waiting for the output.
    assign en3   = !r_v3 || o_box.ready;
    assign move2 = r_v2 && (!pass2 || en3);
    assign en2   = !r_v2 || move2;
    assign move1 = r_v1 && en2;
    assign en1   = !r_v1 || move1;
    assign move0 = r_v0 && (!last0 || en1);
    assign en0   = !r_v0 || move0;
    assign i_det.ready = en0;

    // Record length, with a zero class count acting as one and a large one clamped.
    always_comb begin
        if (r_class_count == '0) begin
            classes = POS_W'(1);
        end else if (r_class_count > CLASS_CNT_W'(MAX_CLASSES)) begin
            classes = POS_W'(MAX_CLASSES);
        end else begin
            classes = POS_W'(r_class_count);
        end
        last_pos = POS_LAST_BASE + classes;
        last0    = (r_pos >= last_pos);
    end

    // Field capture and running arg-max for the element in the input register.
    always_comb begin
        n_cx       = r_cx;
        n_cy       = r_cy;
        n_w        = r_w;
        n_h        = r_h;
        n_obj      = r_obj;
        n_best     = r_best;
        n_best_cls = r_best_cls;
        if (r_pos == POS_CENTRE_X) begin
            n_cx = r_val0;
        end else if (r_pos == POS_CENTRE_Y) begin
            n_cy = r_val0;
        end else if (r_pos == POS_WIDTH) begin
            n_w = r_val0;
        end else if (r_pos == POS_HEIGHT) begin
            n_h = r_val0;
        end else if (r_pos == POS_OBJECTNESS) begin
            n_obj = r_val0;
        end else if (r_pos == POS_FIRST_CLS) begin
            n_best     = r_val0;
            n_best_cls = '0;
        end else if (r_val0 > r_best) begin
            // Strictly greater, so the earlier class keeps a tie.
            n_best     = r_val0;
            n_best_cls = LABEL_W'(r_pos - POS_FIRST_CLS);
        end
    end

    // Element position and anchor counter advance.
    always_comb begin
        anchor_inc = {1'b0, r_anchor} + 1'b1;
        if (last0) begin
            n_pos = '0;
            if (r_anchor_count != '0 && anchor_inc >= {1'b0, r_anchor_count}) begin
                n_anchor = '0;
            end else begin
                n_anchor = anchor_inc[ANCHOR_W-1:0];
            end
        end else begin
            n_pos    = r_pos + 1'b1;
            n_anchor = r_anchor;
        end
    end

    // Operands for the multiply and the box corners.
    always_comb begin
        mag_best = abs_val(r_best1);
        mag_obj  = abs_val(r_obj1);
        neg1     = r_best1[VALUE_WIDTH-1] != r_obj1[VALUE_WIDTH-1];
        thr_ext  = {{(VALUE_WIDTH+1-THRESH_W){1'b0}}, r_conf_threshold};
        left1    = sub_half(r_cx1, r_w1);
        top1     = sub_half(r_cy1, r_h1);
    end

    // Round to nearest (ties away from zero), saturate, restore sign, threshold.
    always_comb begin
        rounded = r_prod2 + PROD_W'(1 << (FRAC_BITS - 1));
        mag_q   = rounded[PROD_W-1:FRAC_BITS];
        limit_q = {{(PROD_W-FRAC_BITS-VALUE_WIDTH+1){1'b0}}, {(VALUE_WIDTH-1){1'b1}}}
                  + (PROD_W-FRAC_BITS)'(r_neg2);
        sat_q   = (mag_q > limit_q) ? limit_q : mag_q;
        prod2   = r_neg2 ? t_value'(~sat_q[VALUE_WIDTH-1:0] + 1'b1)
                         : t_value'(sat_q[VALUE_WIDTH-1:0]);
        pass2   = r_obj_ok2 && ($signed({prod2[VALUE_WIDTH-1], prod2}) > thr_ext);
    end

    // Valid bits and record counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0       <= 1'b0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_pos      <= '0;
            r_anchor   <= '0;
            r_cx       <= '0;
            r_cy       <= '0;
            r_w        <= '0;
            r_h        <= '0;
            r_obj      <= '0;
            r_best     <= '0;
            r_best_cls <= '0;
        end else begin
            if (en0) begin
                r_v0 <= i_det.valid;
            end
            if (en1) begin
                r_v1 <= move0 && last0;
            end
            if (en2) begin
                r_v2 <= move1;
            end
            if (en3) begin
                r_v3 <= move2 && pass2;
            end
            if (move0) begin
                r_pos      <= n_pos;
                r_anchor   <= n_anchor;
                r_cx       <= n_cx;
                r_cy       <= n_cy;
                r_w        <= n_w;
                r_h        <= n_h;
                r_obj      <= n_obj;
                r_best     <= n_best;
                r_best_cls <= n_best_cls;
            end
        end
    end

    // Payload registers of the four stages.
    always_ff @(posedge i_clk) begin
        if (en0 && i_det.valid) begin
            r_val0 <= i_det.value;
        end
        if (move0 && last0 && en1) begin
            r_cx1   <= n_cx;
            r_cy1   <= n_cy;
            r_w1    <= n_w;
            r_h1    <= n_h;
            r_obj1  <= n_obj;
            r_best1 <= n_best;
            r_cls1  <= n_best_cls;
            r_idx1  <= r_anchor;
        end
        if (move1) begin
            r_prod2   <= PROD_W'(mag_best) * PROD_W'(mag_obj);
            r_neg2    <= neg1;
            r_obj_ok2 <= $signed({r_obj1[VALUE_WIDTH-1], r_obj1}) >= thr_ext;
            r_left2   <= left1;
            r_top2    <= top1;
            r_w2      <= r_w1;
            r_h2      <= r_h1;
            r_cls2    <= r_cls1;
            r_idx2    <= r_idx1;
        end
        if (move2 && pass2) begin
            r_left3  <= r_left2;
            r_top3   <= r_top2;
            r_w3     <= r_w2;
            r_h3     <= r_h2;
            r_score3 <= prod2;
            r_cls3   <= r_cls2;
            r_idx3   <= r_idx2;
        end
    end

    // Result channel.
    assign o_box.valid        = r_v3;
    assign o_box.box_left     = r_left3;
    assign o_box.box_top      = r_top3;
    assign o_box.box_width    = r_w3;
    assign o_box.box_height   = r_h3;
    assign o_box.class_label  = r_cls3;
    assign o_box.score        = r_score3;
    assign o_box.anchor_index = r_idx3;

`ifndef SYNTH
    // The element position never runs past the longest record.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_MAX)
        else $error("element position beyond the longest record");

    // A new result only comes from an item held in the product stage.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v3) |-> $past(r_v2))
        else $error("result appeared without a product stage item");

    // A product stage item waiting on a full output keeps its place.
    a_stage2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && pass2 && !en3) |=> r_v2)
        else $error("product stage item lost while the output was stalled");
`endif

endmodule
